FILE: hdl/bmaf_pkg.sv
// Shared types, constants and helpers for the slot bitmap find-free block.
`default_nettype none
package bmaf_pkg;

  localparam int unsigned MAP_BYTES_DEF = 128;
  localparam int unsigned CFG_W         = 8;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned TDATA_W       = 16;
  localparam logic [7:0]  FULL_BYTE     = 8'hFF;
  localparam logic [CFG_W-1:0] BYTES_IN_USE_RST = 8'd128;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TEST  = 2'd1;
  localparam logic [1:0] OP_FIND  = 2'd2;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] found_index;
    logic             bit_state;
  } res_t;

  // position of the lowest clear bit; 0 if the byte is full
  function automatic logic [2:0] lowest_clear(input logic [7:0] b);
    logic [2:0] pos;
    logic       hit;
    pos = 3'd0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && !b[i]) begin
        pos = 3'(i);
        hit = 1'b1;
      end
    end
    return pos;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bmaf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bmaf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/bitmap_allocator_find_free_core.sv
// Top level of the slot bitmap: write bit, test bit and find first clear bit.
//
// The map lives in one MAP_BYTES x 8 RAM with a registered read.
// After reset the block sweeps the RAM to zero, one byte per cycle, and
// s_axis_tready stays low until the sweep is done (configuration writes are taken).
// A write or test issues the byte read in the accept cycle; in the next cycle
// the block reads the byte and, for a write, modifies and writes it back. A find
// reads map bytes in order from byte 0, up to the scan length, and stops at the
// first byte with a clear bit: the single read port delivers one map byte per cycle.
// Results land in an output register, so a new word is accepted while a result
// still waits; a second finished result is held until the output register frees up.
`default_nettype none
module bitmap_allocator_find_free_core #(
  parameter int unsigned MAP_BYTES = bmaf_pkg::MAP_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bmaf_pkg::CFG_W-1:0]  cfg_wdata_i,   // bytes_in_use
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [bmaf_pkg::TDATA_W-1:0] s_axis_tdata, // [9:0] bit_index, [10] set_value
  input  wire logic [1:0]                  s_axis_tuser,  // [1:0] opcode
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [bmaf_pkg::TDATA_W-1:0]     m_axis_tdata,  // [0] bit_state, [10:1] found_index
  output logic                             m_axis_tuser   // [0] status
);
  import bmaf_pkg::*;

  localparam int unsigned AW  = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned LWC = $clog2(MAP_BYTES + 1);
  localparam int unsigned LW  = (LWC > CFG_W) ? LWC : CFG_W;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_ACCESS = 4'b0100,
    ST_WAIT   = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] cfg_q;
  logic [AW-1:0]    clr_q, clr_d;
  logic [1:0]       op_q;
  logic [2:0]       pos_q;
  logic             setv_q, in_rng_q;
  logic [AW-1:0]    addr_q;
  logic [LW-1:0]    len_q, cnt_q, cnt_d, cnt_nxt;
  res_t             res_q, res_d, res_c;
  logic             mvalid_q, mvalid_d;
  res_t             mres_q, mres_d;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  logic             accept, out_free, done;
  logic [6:0]       in_byte;
  logic             in_rng;
  logic [LW-1:0]    len_in;
  logic [LW+2:0]    found_w;
  logic [7:0]       bit_mask;

  bmaf_ram #(
    .WIDTH (8),
    .DEPTH (MAP_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mvalid_q || m_axis_tready;
  assign in_byte       = s_axis_tdata[9:3];
  assign in_rng        = LW'(in_byte) < LW'(MAP_BYTES);
  assign len_in        = (LW'(cfg_q) > LW'(MAP_BYTES)) ? LW'(MAP_BYTES) : LW'(cfg_q);
  assign cnt_nxt       = cnt_q + LW'(1);
  assign found_w       = {cnt_q, lowest_clear(ram_rdata)};
  assign bit_mask      = 8'(1) << pos_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cnt_d     = cnt_q;
    res_d     = res_q;
    mvalid_d  = mvalid_q && !m_axis_tready;
    mres_d    = mres_q;
    ram_we    = 1'b0;
    ram_waddr = addr_q;
    ram_wdata = setv_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
    ram_raddr = AW'(in_byte);
    res_c     = '0;
    done      = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(MAP_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_ACCESS;
          cnt_d   = '0;
          if (s_axis_tuser == OP_FIND) begin
            ram_raddr = '0;
          end
        end
      end
      ST_ACCESS: begin
        unique case (op_q)
          OP_WRITE: begin
            done   = 1'b1;
            ram_we = in_rng_q;
          end
          OP_TEST: begin
            done            = 1'b1;
            res_c.bit_state = in_rng_q && ram_rdata[pos_q];
          end
          OP_FIND: begin
            if (len_q == '0) begin
              done         = 1'b1;
              res_c.status = 1'b1;
            end else if (ram_rdata != FULL_BYTE) begin
              done              = 1'b1;
              res_c.found_index = found_w[IDX_W-1:0];
            end else if (cnt_nxt == len_q) begin
              done         = 1'b1;
              res_c.status = 1'b1;
            end else begin
              cnt_d     = cnt_nxt;
              ram_raddr = AW'(cnt_nxt);
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          if (out_free) begin
            mvalid_d = 1'b1;
            mres_d   = res_c;
            state_d  = ST_IDLE;
          end else begin
            res_d   = res_c;
            state_d = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mres_d   = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      cfg_q    <= BYTES_IN_USE_RST;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      mvalid_q <= mvalid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    mres_q <= mres_d;
    if (accept) begin
      op_q     <= s_axis_tuser;
      pos_q    <= s_axis_tdata[2:0];
      setv_q   <= s_axis_tdata[10];
      in_rng_q <= in_rng;
      addr_q   <= AW'(in_byte);
      len_q    <= len_in;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {{(TDATA_W - IDX_W - 1){1'b0}}, mres_q.found_index, mres_q.bit_state};
  assign m_axis_tuser  = mres_q.status;

endmodule
`default_nettype wire
